// ===== src/ett_pkg.sv =====
// Shared constants and types for the one-shot timer table.
package ett_pkg;

	localparam int SLOTS  = 64;
	localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;

	localparam int TIME_W  = 32;
	localparam int HND_W   = 8;
	localparam int WORD_W  = 32;
	localparam int SLOT_PW = 6;
	localparam int WAIT_W  = 10;
	localparam int ENTRY_W = TIME_W + HND_W + 2 * WORD_W;

	localparam logic [WAIT_W-1:0] WAIT_MAX = WAIT_W'(1000);
	localparam logic [WAIT_W-1:0] WAIT_MIN = WAIT_W'(10);

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_DEL  = 2'd1,
		OP_TICK = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRED = 2'd0,
		KIND_ADD   = 2'd1,
		KIND_DEL   = 2'd2,
		KIND_SUM   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_BAD_SLOT = 3'd2,
		STAT_MISMATCH = 3'd3,
		STAT_BAD_HND  = 3'd4
	} status_t;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [HND_W-1:0]  hnd;
		logic [WORD_W-1:0] word_a;
		logic [WORD_W-1:0] word_b;
	} entry_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_FIND  = 6'b000010,
		ST_DCHK  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_REPLY = 6'b010000,
		ST_SUM   = 6'b100000
	} state_t;

endpackage

// ===== src/expiry_timer_table_core.sv =====
// One-shot timer table: add, delete and tick scan over a single entry memory.
//
// Timer table with slots 1 to SLOTS-1; slot 0 is never assigned. One request is
// taken at a time and req_stall stays high until its last result has been
// placed in the output register. The entries sit in one synchronous memory with
// a single read port, so slots are handled one at a time: a tick visits slots 1
// to SLOTS-1 in order and then gives the summary, an add inspects slots up to and
// including the first free one, a delete reads its slot once (or is rejected at
// once), and a waiting result that res_stall holds stalls the request. The
// result register lets the next request be taken while the last result of the
// previous one still waits. No clearing pass is needed after reset.
module expiry_timer_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [1:0]                          operation,
	input  logic [ett_pkg::TIME_W-1:0]          time_value,
	input  logic [ett_pkg::HND_W-1:0]           handler,
	input  logic signed [ett_pkg::WORD_W-1:0]   data_a,
	input  logic signed [ett_pkg::WORD_W-1:0]   data_b,
	input  logic [ett_pkg::SLOT_PW-1:0]         slot,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [1:0]                          kind,
	output logic [ett_pkg::SLOT_PW-1:0]         slot_out,
	output logic [ett_pkg::HND_W-1:0]           handler_out,
	output logic signed [ett_pkg::WORD_W-1:0]   data_a_out,
	output logic signed [ett_pkg::WORD_W-1:0]   data_b_out,
	output logic [2:0]                          status,
	output logic [ett_pkg::WAIT_W-1:0]          wait_ms,
	output logic                                last
);

	localparam logic [ett_pkg::SLOT_W-1:0] LAST_IDX  = ett_pkg::SLOT_W'(ett_pkg::SLOTS - 1);
	localparam logic [ett_pkg::SLOT_W-1:0] FIRST_IDX = ett_pkg::SLOT_W'(1);

	ett_pkg::state_t                 state_q, state_nxt;
	logic [ett_pkg::SLOTS-1:0]       in_use_q;
	logic [ett_pkg::SLOT_W-1:0]      idx_q, idx_nxt;
	logic [ett_pkg::WAIT_W-1:0]      min_q, min_nxt;

	logic [ett_pkg::TIME_W-1:0]      tv_q;
	logic [ett_pkg::HND_W-1:0]       hd_q;
	logic [ett_pkg::WORD_W-1:0]      da_q;
	logic [ett_pkg::WORD_W-1:0]      db_q;
	logic [ett_pkg::SLOT_PW-1:0]     slot_q;

	ett_pkg::kind_t                  rep_kind_q, rep_kind_nxt;
	ett_pkg::status_t                rep_stat_q, rep_stat_nxt;
	logic [ett_pkg::SLOT_PW-1:0]     rep_slot_q, rep_slot_nxt;

	ett_pkg::entry_t                 mem [ett_pkg::SLOTS];
	ett_pkg::entry_t                 rd_q;
	ett_pkg::entry_t                 wdata;
	logic                            rd_en, wr_en;
	logic [ett_pkg::SLOT_W-1:0]      rd_addr;

	logic                            accept, out_busy, out_load;
	logic                            set_use, clr_use;
	logic [ett_pkg::SLOT_W-1:0]      use_idx;
	logic [ett_pkg::SLOT_W-1:0]      req_idx;
	logic                            slot_ok;

	logic [ett_pkg::TIME_W-1:0]      diff;
	logic                            cur_use, fire;

	ett_pkg::kind_t                  o_kind;
	ett_pkg::status_t                o_stat;
	logic [ett_pkg::SLOT_PW-1:0]     o_slot;
	logic [ett_pkg::HND_W-1:0]       o_hnd;
	logic [ett_pkg::WORD_W-1:0]      o_a, o_b;
	logic [ett_pkg::WAIT_W-1:0]      o_wait;
	logic                            o_last;

	assign req_stall = (state_q != ett_pkg::ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_busy  = res_valid && res_stall;
	assign req_idx   = slot[ett_pkg::SLOT_W-1:0];
	assign slot_ok   = (slot != '0) && ({1'b0, slot} < 7'(ett_pkg::SLOTS)) && in_use_q[req_idx];

	assign diff    = rd_q.due - tv_q;
	assign cur_use = in_use_q[idx_q];
	assign fire    = cur_use && ($signed(diff) <= 0);

	assign wdata = '{due: tv_q, hnd: hd_q, word_a: da_q, word_b: db_q};

	always_comb begin
		state_nxt    = state_q;
		idx_nxt      = idx_q;
		min_nxt      = min_q;
		rep_kind_nxt = rep_kind_q;
		rep_stat_nxt = rep_stat_q;
		rep_slot_nxt = rep_slot_q;
		rd_en        = 1'b0;
		rd_addr      = idx_q;
		wr_en        = 1'b0;
		set_use      = 1'b0;
		clr_use      = 1'b0;
		use_idx      = idx_q;
		out_load     = 1'b0;
		o_kind       = ett_pkg::KIND_FIRED;
		o_stat       = ett_pkg::STAT_OK;
		o_slot       = '0;
		o_hnd        = '0;
		o_a          = '0;
		o_b          = '0;
		o_wait       = '0;
		o_last       = 1'b0;

		case (state_q)
			ett_pkg::ST_IDLE: begin
				if (accept) begin
					case (operation)
						ett_pkg::OP_ADD: begin
							rep_kind_nxt = ett_pkg::KIND_ADD;
							rep_slot_nxt = '0;
							idx_nxt      = FIRST_IDX;
							if (handler == '0) begin
								rep_stat_nxt = ett_pkg::STAT_BAD_HND;
								state_nxt    = ett_pkg::ST_REPLY;
							end else begin
								state_nxt = ett_pkg::ST_FIND;
							end
						end
						ett_pkg::OP_DEL: begin
							rep_kind_nxt = ett_pkg::KIND_DEL;
							rep_slot_nxt = slot;
							if (slot_ok) begin
								rd_en     = 1'b1;
								rd_addr   = req_idx;
								state_nxt = ett_pkg::ST_DCHK;
							end else begin
								rep_stat_nxt = ett_pkg::STAT_BAD_SLOT;
								state_nxt    = ett_pkg::ST_REPLY;
							end
						end
						ett_pkg::OP_TICK: begin
							rd_en     = 1'b1;
							rd_addr   = FIRST_IDX;
							idx_nxt   = FIRST_IDX;
							min_nxt   = ett_pkg::WAIT_MAX;
							state_nxt = ett_pkg::ST_SCAN;
						end
						default: begin
							state_nxt = ett_pkg::ST_IDLE;
						end
					endcase
				end
			end
			ett_pkg::ST_FIND: begin
				if (!cur_use) begin
					wr_en        = 1'b1;
					set_use      = 1'b1;
					rep_stat_nxt = ett_pkg::STAT_OK;
					rep_slot_nxt = ett_pkg::SLOT_PW'(idx_q);
					state_nxt    = ett_pkg::ST_REPLY;
				end else if (idx_q == LAST_IDX) begin
					rep_stat_nxt = ett_pkg::STAT_FULL;
					state_nxt    = ett_pkg::ST_REPLY;
				end else begin
					idx_nxt = idx_q + 1'b1;
				end
			end
			ett_pkg::ST_DCHK: begin
				use_idx = slot_q[ett_pkg::SLOT_W-1:0];
				if (rd_q.hnd == hd_q) begin
					clr_use      = 1'b1;
					rep_stat_nxt = ett_pkg::STAT_OK;
				end else begin
					rep_stat_nxt = ett_pkg::STAT_MISMATCH;
				end
				state_nxt = ett_pkg::ST_REPLY;
			end
			ett_pkg::ST_SCAN: begin
				// hold the slot while a fired result cannot be placed
				if (!(fire && out_busy)) begin
					if (cur_use && ($signed(diff) < $signed({22'd0, min_q}))) begin
						min_nxt = ($signed(diff) < $signed({22'd0, ett_pkg::WAIT_MIN})) ?
							ett_pkg::WAIT_MIN : diff[ett_pkg::WAIT_W-1:0];
					end
					if (fire) begin
						clr_use  = 1'b1;
						out_load = 1'b1;
						o_kind   = ett_pkg::KIND_FIRED;
						o_slot   = ett_pkg::SLOT_PW'(idx_q);
						o_hnd    = rd_q.hnd;
						o_a      = rd_q.word_a;
						o_b      = rd_q.word_b;
					end
					if (idx_q == LAST_IDX) begin
						state_nxt = ett_pkg::ST_SUM;
					end else begin
						idx_nxt = idx_q + 1'b1;
						rd_en   = 1'b1;
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			ett_pkg::ST_REPLY: begin
				if (!out_busy) begin
					out_load  = 1'b1;
					o_kind    = rep_kind_q;
					o_stat    = rep_stat_q;
					o_slot    = rep_slot_q;
					o_last    = 1'b1;
					state_nxt = ett_pkg::ST_IDLE;
				end
			end
			ett_pkg::ST_SUM: begin
				if (!out_busy) begin
					out_load  = 1'b1;
					o_kind    = ett_pkg::KIND_SUM;
					o_wait    = min_q;
					o_last    = 1'b1;
					state_nxt = ett_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ett_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ett_pkg::ST_IDLE;
			in_use_q  <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (set_use) in_use_q[use_idx] <= 1'b1;
			if (clr_use) in_use_q[use_idx] <= 1'b0;
			if (out_load) begin
				res_valid <= 1'b1;
			end else if (!res_stall) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_nxt;
		min_q      <= min_nxt;
		rep_kind_q <= rep_kind_nxt;
		rep_stat_q <= rep_stat_nxt;
		rep_slot_q <= rep_slot_nxt;
		if (accept) begin
			tv_q   <= time_value;
			hd_q   <= handler;
			da_q   <= data_a;
			db_q   <= data_b;
			slot_q <= slot;
		end
		if (out_load) begin
			kind        <= o_kind;
			slot_out    <= o_slot;
			handler_out <= o_hnd;
			data_a_out  <= o_a;
			data_b_out  <= o_b;
			status      <= o_stat;
			wait_ms     <= o_wait;
			last        <= o_last;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[idx_q] <= wdata;
		if (rd_en) rd_q <= mem[rd_addr];
	end

`ifndef SYNTH
	a_slot0_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_use_q[0])
		else $error("slot 0 marked in use");

	a_fired_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == ett_pkg::KIND_FIRED) |-> !last)
		else $error("fired result flagged as last");

	a_wait_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == ett_pkg::KIND_SUM) |->
			(wait_ms >= ett_pkg::WAIT_MIN) && (wait_ms <= ett_pkg::WAIT_MAX))
		else $error("summary wait out of range");

	a_tick_scans: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == ett_pkg::OP_TICK) |=> (state_q == ett_pkg::ST_SCAN))
		else $error("tick request did not start a scan");

	a_add_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ett_pkg::ST_FIND) && !in_use_q[idx_q] && (idx_q != '0))
		else $error("entry written over a slot in use");
`endif

endmodule

// ===== sim/expiry_timer_table_core_tb.sv =====
// Self-checking bench for the one-shot timer table: add, delete and tick scans.
`timescale 1ns / 1ps

module expiry_timer_table_core_tb;

	localparam int RANDOM_ITEMS = 480;

	typedef struct packed {
		ett_pkg::op_t                op;
		logic [ett_pkg::TIME_W-1:0]  tval;
		logic [ett_pkg::HND_W-1:0]   hnd;
		logic [ett_pkg::WORD_W-1:0]  wa;
		logic [ett_pkg::WORD_W-1:0]  wb;
		logic [ett_pkg::SLOT_PW-1:0] slot;
		logic                        hold;
	} request_t;

	typedef struct packed {
		ett_pkg::kind_t              kind;
		logic [ett_pkg::SLOT_PW-1:0] slot;
		logic [ett_pkg::HND_W-1:0]   hnd;
		logic [ett_pkg::WORD_W-1:0]  wa;
		logic [ett_pkg::WORD_W-1:0]  wb;
		ett_pkg::status_t            st;
		logic [ett_pkg::WAIT_W-1:0]  wait_ms;
		logic                        last;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                              req_valid = 1'b0;
	logic                              req_stall;
	logic [1:0]                        operation = 2'd0;
	logic [ett_pkg::TIME_W-1:0]        time_value = '0;
	logic [ett_pkg::HND_W-1:0]         handler = '0;
	logic signed [ett_pkg::WORD_W-1:0] data_a = '0;
	logic signed [ett_pkg::WORD_W-1:0] data_b = '0;
	logic [ett_pkg::SLOT_PW-1:0]       slot = '0;
	logic                              res_valid;
	logic                              res_stall = 1'b0;
	logic [1:0]                        kind;
	logic [ett_pkg::SLOT_PW-1:0]       slot_out;
	logic [ett_pkg::HND_W-1:0]         handler_out;
	logic signed [ett_pkg::WORD_W-1:0] data_a_out;
	logic signed [ett_pkg::WORD_W-1:0] data_b_out;
	logic [2:0]                        status;
	logic [ett_pkg::WAIT_W-1:0]        wait_ms;
	logic                              last;

	// timer table as the bench sees it
	bit                         slot_busy [ett_pkg::SLOTS];
	bit [ett_pkg::TIME_W-1:0]   slot_due  [ett_pkg::SLOTS];
	bit [ett_pkg::HND_W-1:0]    slot_hnd  [ett_pkg::SLOTS];
	bit [ett_pkg::WORD_W-1:0]   slot_wa   [ett_pkg::SLOTS];
	bit [ett_pkg::WORD_W-1:0]   slot_wb   [ett_pkg::SLOTS];

	request_t request_queue [$];
	reply_t   owed_replies [$];
	request_t on_port;

	logic [ett_pkg::TIME_W-1:0] clock_ms;
	int made;
	int failures;
	int op_count [4];
	int replies_checked;
	int fired_seen;
	int full_seen;
	int mismatch_seen;
	int burst_left;
	int gap_left;

	expiry_timer_table_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.operation   (operation),
		.time_value  (time_value),
		.handler     (handler),
		.data_a      (data_a),
		.data_b      (data_b),
		.slot        (slot),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.kind        (kind),
		.slot_out    (slot_out),
		.handler_out (handler_out),
		.data_a_out  (data_a_out),
		.data_b_out  (data_b_out),
		.status      (status),
		.wait_ms     (wait_ms),
		.last        (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Work out the replies one request causes and update the table.
	task automatic apply_request(input request_t r);
		int                 i;
		int                 found;
		int                 nearest;
		logic signed [31:0] diff;
		reply_t             rep;
		case (r.op)
			ett_pkg::OP_ADD: begin
				rep = '0;
				rep.kind = ett_pkg::KIND_ADD;
				rep.last = 1'b1;
				found = 0;
				for (i = 1; i < ett_pkg::SLOTS && found == 0; i++)
					if (!slot_busy[i])
						found = i;
				if (r.hnd == '0) begin
					rep.st = ett_pkg::STAT_BAD_HND;
				end else if (found == 0) begin
					rep.st = ett_pkg::STAT_FULL;
				end else begin
					slot_busy[found] = 1'b1;
					slot_due[found] = r.tval;
					slot_hnd[found] = r.hnd;
					slot_wa[found] = r.wa;
					slot_wb[found] = r.wb;
					rep.slot = ett_pkg::SLOT_PW'(found);
					rep.st = ett_pkg::STAT_OK;
				end
				owed_replies.push_back(rep);
			end
			ett_pkg::OP_DEL: begin
				rep = '0;
				rep.kind = ett_pkg::KIND_DEL;
				rep.slot = r.slot;
				rep.last = 1'b1;
				if (r.slot == '0 || int'(r.slot) >= ett_pkg::SLOTS || !slot_busy[r.slot]) begin
					rep.st = ett_pkg::STAT_BAD_SLOT;
				end else if (slot_hnd[r.slot] != r.hnd) begin
					rep.st = ett_pkg::STAT_MISMATCH;
				end else begin
					slot_busy[r.slot] = 1'b0;
					rep.st = ett_pkg::STAT_OK;
				end
				owed_replies.push_back(rep);
			end
			ett_pkg::OP_TICK: begin
				nearest = int'(ett_pkg::WAIT_MAX);
				for (i = 1; i < ett_pkg::SLOTS; i++) begin
					if (slot_busy[i]) begin
						// signed wrap-around distance to the due time
						diff = slot_due[i] - r.tval;
						if (diff < nearest)
							nearest = diff;
						if (diff <= 0) begin
							rep = '0;
							rep.kind = ett_pkg::KIND_FIRED;
							rep.slot = ett_pkg::SLOT_PW'(i);
							rep.hnd = slot_hnd[i];
							rep.wa = slot_wa[i];
							rep.wb = slot_wb[i];
							owed_replies.push_back(rep);
							slot_busy[i] = 1'b0;
						end
					end
				end
				if (nearest < int'(ett_pkg::WAIT_MIN))
					nearest = int'(ett_pkg::WAIT_MIN);
				rep = '0;
				rep.kind = ett_pkg::KIND_SUM;
				rep.wait_ms = ett_pkg::WAIT_W'(nearest);
				rep.last = 1'b1;
				owed_replies.push_back(rep);
			end
			default: ;
		endcase
	endtask

	function automatic int occupied();
		int i;
		int n;
		n = 0;
		for (i = 1; i < ett_pkg::SLOTS; i++)
			n += slot_busy[i];
		return n;
	endfunction

	task automatic queue_request(input ett_pkg::op_t op, input logic [31:0] tval,
			input logic [7:0] hnd, input logic [31:0] wa, input logic [31:0] wb,
			input logic [5:0] sl, input bit hold);
		request_t r;
		r.op = op;
		r.tval = tval;
		r.hnd = hnd;
		r.wa = wa;
		r.wb = wb;
		r.slot = sl;
		r.hold = hold;
		request_queue.push_back(r);
	endtask

	// One random request; mostly well-formed, with a share of raw noise.
	task automatic random_request(input int add_pct, input int del_pct, input int noise_pct);
		request_t r;
		int       i;
		int       pick;
		int       busy [$];
		while (request_queue.size() > 1)
			@(negedge clk);
		r = '0;
		r.hold = ($urandom_range(0, 49) == 0);
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < noise_pct) begin
			r.op = ett_pkg::op_t'($urandom_range(0, 3));
			r.tval = $urandom;
			r.hnd = ett_pkg::HND_W'($urandom);
			r.wa = $urandom;
			r.wb = $urandom;
			r.slot = ett_pkg::SLOT_PW'($urandom);
		end else if (pick < add_pct) begin
			r.op = ett_pkg::OP_ADD;
			r.hnd = ett_pkg::HND_W'($urandom_range(1, 255));
			r.wa = $urandom;
			r.wb = $urandom;
			case ($urandom_range(0, 6))
				0: r.tval = $urandom;
				1: r.tval = clock_ms - $urandom_range(0, 500);
				default: r.tval = clock_ms + $urandom_range(0, 2500);
			endcase
		end else if (pick < add_pct + del_pct) begin
			r.op = ett_pkg::OP_DEL;
			for (i = 1; i < ett_pkg::SLOTS; i++)
				if (slot_busy[i])
					busy.push_back(i);
			if (busy.size() != 0)
				r.slot = ett_pkg::SLOT_PW'(busy[$urandom_range(0, busy.size() - 1)]);
			else
				r.slot = ett_pkg::SLOT_PW'($urandom_range(0, 63));
			r.hnd = ($urandom_range(0, 6) == 0) ? ett_pkg::HND_W'($urandom) : slot_hnd[r.slot];
		end else begin
			r.op = ett_pkg::OP_TICK;
			if ($urandom_range(0, 19) == 0)
				clock_ms = $urandom;
			else
				clock_ms = clock_ms + $urandom_range(0, 1200);
			r.tval = clock_ms;
		end
		if (r.op != ett_pkg::OP_NONE)
			made++;
		request_queue.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			failures++;
		end
	endtask

	// Request driver: bursts of random length, random gaps, optional drain before a request.
	always @(posedge clk) begin : driver
		bit present;
		if (arst_n && (!req_valid || !req_stall)) begin
			if (req_valid) begin
				apply_request(on_port);
				op_count[on_port.op]++;
			end
			present = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (request_queue.size() != 0 &&
					!(request_queue[0].hold && owed_replies.size() != 0)) begin
				on_port = request_queue.pop_front();
				present = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			req_valid <= present;
			if (present) begin
				operation <= on_port.op;
				time_value <= on_port.tval;
				handler <= on_port.hnd;
				data_a <= on_port.wa;
				data_b <= on_port.wb;
				slot <= on_port.slot;
			end
		end
	end

	// Reply monitor and receiver stall pattern.
	always @(posedge clk) begin : monitor
		reply_t want;
		int     stall_mode;
		int     stall_left;
		bit     stall_next;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (owed_replies.size() == 0) begin
					$error("unexpected reply: kind %0d slot %0d status %0d",
						kind, slot_out, status);
					failures++;
				end else begin
					want = owed_replies.pop_front();
					check_field("kind", want.kind, kind);
					check_field("slot_out", want.slot, slot_out);
					check_field("handler_out", want.hnd, handler_out);
					check_field("data_a_out", want.wa, data_a_out);
					check_field("data_b_out", want.wb, data_b_out);
					check_field("status", want.st, status);
					check_field("wait_ms", want.wait_ms, wait_ms);
					check_field("last", want.last, last);
					replies_checked++;
					fired_seen += (want.kind == ett_pkg::KIND_FIRED);
					full_seen += (want.st == ett_pkg::STAT_FULL);
					mismatch_seen += (want.st == ett_pkg::STAT_MISMATCH);
				end
			end
			if (stall_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(32, 300);
			end else begin
				stall_left--;
			end
			case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				2: stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = ~res_stall;
			endcase
			res_stall <= stall_next;
		end
	end

	initial begin : stimulus
		int phase;
		int extra;
		int k;
		clock_ms = 32'd5000;
		made = 0;

		// empty table, bad handler, three timers, then deletes, a no-op and ticks
		queue_request(ett_pkg::OP_TICK, 32'd0, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_ADD, 32'd50, 8'd0, '1, '1, 6'd63, 1'b0);
		queue_request(ett_pkg::OP_ADD, 32'd100, 8'hFF, 32'h7FFFFFFF, 32'h80000000, 6'd0,
			1'b0);
		queue_request(ett_pkg::OP_ADD, 32'hFFFFFFFF, 8'h01, 32'hFFFFFFFF, 32'h0, 6'd0,
			1'b0);
		queue_request(ett_pkg::OP_ADD, 32'd5, 8'h80, 32'h0, 32'hFFFFFFFF, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'd1, '0, '0, 6'd63, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'd7, '0, '0, 6'd2, 1'b0);
		queue_request(ett_pkg::OP_NONE, '1, '1, '1, '1, '1, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'd0, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'd95, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'hFF, '0, '0, 6'd1, 1'b1);
		// half-range distances: most negative fires, most positive does not
		queue_request(ett_pkg::OP_ADD, 32'h80000000, 8'd2, 32'd1, 32'd2, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_ADD, 32'h7FFFFFFF, 8'd3, 32'd3, 32'd4, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'd0, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'h7FFFFFFF - 32'd500, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'h7FFFFFFE, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'h7FFFFFFF, 8'd0, '0, '0, 6'd0, 1'b0);
		// waits above the ceiling and in the middle of the range
		queue_request(ett_pkg::OP_ADD, 32'd2000, 8'd4, 32'd5, 32'd6, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_ADD, 32'd1500, 8'd5, 32'd7, 32'd8, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'd0, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_TICK, 32'd1200, 8'd0, '0, '0, 6'd0, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'd5, '0, '0, 6'd2, 1'b0);
		queue_request(ett_pkg::OP_DEL, 32'd0, 8'd4, '0, '0, 6'd1, 1'b0);

		phase = 0;
		while (made < RANDOM_ITEMS) begin
			if (phase % 4 == 1) begin
				// fill the table and push a few adds past full
				extra = 0;
				for (k = 0; k < 120 && extra < 6; k++) begin
					random_request(100, 0, 0);
					if (occupied() >= ett_pkg::SLOTS - 1)
						extra++;
				end
			end else if (phase % 4 == 2) begin
				repeat (40) random_request(15, 25, 8);
			end else begin
				repeat (40) random_request(40, 25, 8);
			end
			phase++;
		end

		while (request_queue.size() != 0 || req_valid)
			@(negedge clk);
		while (owed_replies.size() != 0)
			@(negedge clk);
		repeat (2 * ett_pkg::SLOTS) @(negedge clk);

		$display("Requests: %0d adds, %0d deletes, %0d ticks, %0d ignored; %0d replies checked",
			op_count[ett_pkg::OP_ADD], op_count[ett_pkg::OP_DEL],
			op_count[ett_pkg::OP_TICK], op_count[ett_pkg::OP_NONE], replies_checked);
		$display("Timers fired: %0d, table-full replies: %0d, handler mismatches: %0d",
			fired_seen, full_seen, mismatch_seen);
		if (failures == 0)
			$display("PASS expiry_timer_table_core");
		else
			$display("FAIL expiry_timer_table_core");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("FAIL expiry_timer_table_core");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/ett_pkg.sv
src/expiry_timer_table_core.sv
sim/expiry_timer_table_core_tb.sv
